// ----- design/uule_pkg.sv -----
// ----------------------------------------------------------------------------
// uule_pkg
// Word types shared by the uuencode line encoder and its test harnesses.
// ----------------------------------------------------------------------------
package uule_pkg;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [6:0] out_char;
    logic       run_last;
  } out_word_t;

  // Character codes of the printable mapping
  localparam logic [6:0] BQ_CHAR    = 7'd96;
  localparam logic [6:0] SPACE_CHAR = 7'd32;
  localparam logic [6:0] NL_CHAR    = 7'd10;

endpackage

// ----- design/uuencode_line_encoder.sv -----
// ----------------------------------------------------------------------------
// uuencode_line_encoder
// Collects raw bytes into a line buffer and emits uuencoded lines, one
// character per output word.
// ----------------------------------------------------------------------------
// Timing: the first character of a line, its length character, is registered
//   into the output word from S_LEN, which is entered when the word that
//   completes or ends the line is accepted.
// Flow: a byte that does not close a line is only stored. A line goes out as
//   the length character, then per group three buffer reads and four
//   characters, then the newline; at end of input the closing empty line
//   follows. No input is taken meanwhile; character states wait on the receiver.
// Reset (rst, synchronous): sequencer idle, line empty, output word dropped.
//   The line buffer is not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module uuencode_line_encoder #(
  parameter int LINE_BYTES = 45
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  uule_pkg::in_word_t   in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output uule_pkg::out_word_t  out_word
);

  localparam int AW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int CW = $clog2(LINE_BYTES + 1);  // held count, 0..LINE_BYTES
  localparam int IW = $clog2(LINE_BYTES + 3);  // byte position, up to n+2

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LEN   = 7'b0000010,   // length character
    S_FETCH = 7'b0000100,   // read three bytes of a group
    S_CHAR  = 7'b0001000,   // four characters of a group
    S_NL    = 7'b0010000,   // newline closing a data line
    S_END0  = 7'b0100000,   // backquote of the closing empty line
    S_END1  = 7'b1000000    // newline of the closing empty line
  } state_t;

  state_t          state;
  logic [CW-1:0]   held;       // bytes in the buffer
  logic [CW-1:0]   line_n;     // bytes of the line being emitted
  logic            fin_pend;   // closing empty line follows this line
  logic [IW-1:0]   byte_pos;   // first byte of the current group
  logic [1:0]      step;       // read step in S_FETCH, character in S_CHAR
  logic [23:0]     grp;        // group being encoded, shifts left 6 a char
  logic            rd_ok_d;    // last read was inside the line

  logic [CW-1:0]   held_inc;
  logic            acc;
  logic            full;
  logic            do_line;
  logic [IW-1:0]   rd_pos;
  logic            rd_ok;
  logic [IW-1:0]   next_pos;
  logic [7:0]      rdata;
  logic            adv;
  logic            emit;
  logic [5:0]      enc_val;
  logic [6:0]      enc_char;
  logic [6:0]      emit_char;
  logic            emit_last;

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign held_inc = held + CW'(1);
  assign full     = in_word.has_byte && (held_inc == CW'(LINE_BYTES));
  // a line goes out when the buffer fills, or at end with anything held
  assign do_line  = in_word.has_byte ? (full || in_word.end_of_input)
                                     : (in_word.end_of_input && (held != '0));

  // --------------------------------------------------------------------------
  // Buffer reads: one byte a cycle, positions past the line read as zero
  // --------------------------------------------------------------------------
  assign rd_pos   = byte_pos + IW'(step);
  assign rd_ok    = (state == S_FETCH) && (step != 2'd3) && (rd_pos < IW'(line_n));
  assign next_pos = byte_pos + IW'(3);

  uule_store #(
    .DEPTH (LINE_BYTES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (acc && in_word.has_byte),
    .waddr (held[AW-1:0]),
    .wdata (in_word.data_byte),
    .re    (rd_ok),
    .raddr (rd_pos[AW-1:0]),
    .rdata (rdata)
  );

  // --------------------------------------------------------------------------
  // Character selection into the shared unit
  // --------------------------------------------------------------------------
  assign adv = !out_valid || out_ready;

  always_comb begin
    enc_val   = 6'd0;
    emit      = 1'b0;
    emit_char = uule_pkg::NL_CHAR;
    emit_last = 1'b0;
    unique case (state)
      S_LEN: begin
        enc_val   = 6'(line_n);
        emit      = adv;
        emit_char = enc_char;
      end
      S_CHAR: begin
        enc_val   = grp[23:18];
        emit      = adv;
        emit_char = enc_char;
      end
      S_NL: begin
        emit      = adv;
        emit_last = !fin_pend;
      end
      S_END0: begin
        emit      = adv;
        emit_char = enc_char;
      end
      S_END1: begin
        emit      = adv;
        emit_last = 1'b1;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  uule_enc u_enc (
    .val       (enc_val),
    .char_code (enc_char)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      held     <= '0;
      fin_pend <= 1'b0;
      step     <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (do_line) begin
              line_n   <= in_word.has_byte ? held_inc : held;
              held     <= '0;
              fin_pend <= in_word.end_of_input;
              state    <= S_LEN;
            end else if (in_word.end_of_input) begin
              held  <= '0;
              state <= S_END0;
            end else if (in_word.has_byte) begin
              held <= held_inc;
            end
          end
        end
        S_LEN: begin
          if (adv) begin
            byte_pos <= '0;
            step     <= 2'd0;
            state    <= S_FETCH;
          end
        end
        S_FETCH: begin
          step <= step + 2'd1;
          if (step == 2'd3) begin
            state <= S_CHAR;
          end
        end
        S_CHAR: begin
          if (adv) begin
            step <= step + 2'd1;
            if (step == 2'd3) begin
              byte_pos <= next_pos;
              state    <= (next_pos < IW'(line_n)) ? S_FETCH : S_NL;
            end
          end
        end
        S_NL: begin
          if (adv) begin
            state <= fin_pend ? S_END0 : S_IDLE;
          end
        end
        S_END0: begin
          if (adv) begin
            state <= S_END1;
          end
        end
        S_END1: begin
          if (adv) begin
            fin_pend <= 1'b0;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // group register: bytes shift in during fetch, 6-bit fields shift out
  always_ff @(posedge clk) begin
    rd_ok_d <= rd_ok;
    if (state == S_FETCH && step != 2'd0) begin
      grp <= {grp[15:0], rd_ok_d ? rdata : 8'd0};
    end else if (state == S_CHAR && adv) begin
      grp <= {grp[17:0], 6'd0};
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word.out_char <= emit_char;
      out_word.run_last <= emit_last;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_held_below_line: assert property (@(posedge clk) disable iff (rst)
    held < CW'(LINE_BYTES))
    else $error("held count reached a full line without emitting");

  a_line_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LEN) |-> (line_n != '0))
    else $error("empty data line started");

  a_group_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHAR) |-> (byte_pos < IW'(line_n)))
    else $error("group start beyond line length");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_END1 && adv) |=> (out_valid && out_word.run_last
                                  && state == S_IDLE))
    else $error("closing newline not marked last");

  a_busy_holds_input: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(held))
    else $error("held count changed while emitting");

endmodule

// ----- design/uule_store.sv -----
// ----------------------------------------------------------------------------
// uule_store
// Line buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module uule_store #(
  parameter int DEPTH = 45,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/uule_enc.sv -----
// ----------------------------------------------------------------------------
// uule_enc
// Shared character unit: maps a 6-bit value to its printable character.
// ----------------------------------------------------------------------------
module uule_enc (
  input  logic [5:0] val,
  output logic [6:0] char_code
);

  // zero goes out as a backquote, everything else is offset by a space
  assign char_code = (val == 6'd0) ? uule_pkg::BQ_CHAR
                                   : (uule_pkg::SPACE_CHAR + {1'b0, val});

endmodule

// ----- verif/uule_checker.sv -----
// ----------------------------------------------------------------------------
// uule_checker
// Watches both channels of the uuencode line encoder. It keeps its own line
// buffer, works out the characters owed for each accepted input word, and
// compares each accepted output word against the oldest owed character.
// ----------------------------------------------------------------------------
module uule_checker #(
  parameter int LINE_BYTES = 45
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  uule_pkg::in_word_t  in_word,
  input  logic                out_valid,
  input  logic                out_ready,
  input  uule_pkg::out_word_t out_word,
  output int                  fail_count,
  output int                  chars_owed
);

  logic [7:0]          held_bytes [LINE_BYTES];
  int                  held_n;
  uule_pkg::out_word_t run_chars_q [$];   // characters caused by the current input word
  uule_pkg::out_word_t owed_chars_q [$];  // characters still to come from the encoder

  function automatic logic [6:0] printable(input logic [5:0] v);
    return (v == 6'd0) ? uule_pkg::BQ_CHAR : uule_pkg::SPACE_CHAR + 7'(v);
  endfunction

  function void push_char(input logic [6:0] c);
    uule_pkg::out_word_t w;
    w.out_char = c;
    w.run_last = 1'b0;
    run_chars_q.push_back(w);
  endfunction

  // Length char, four chars per started group (zero padded), newline
  function void emit_line();
    logic [7:0] b0, b1, b2;
    push_char(printable(6'(held_n)));
    for (int i = 0; i < held_n; i += 3) begin
      b0 = held_bytes[i];
      b1 = (i + 1 < held_n) ? held_bytes[i + 1] : 8'h00;
      b2 = (i + 2 < held_n) ? held_bytes[i + 2] : 8'h00;
      push_char(printable(b0[7:2]));
      push_char(printable({b0[1:0], b1[7:4]}));
      push_char(printable({b1[3:0], b2[7:6]}));
      push_char(printable(b2[5:0]));
    end
    push_char(uule_pkg::NL_CHAR);
    held_n = 0;
  endfunction

  function void predict_word(input uule_pkg::in_word_t w);
    uule_pkg::out_word_t tail;
    run_chars_q.delete();
    if (w.has_byte) begin
      held_bytes[held_n] = w.data_byte;
      held_n++;
      if (held_n >= LINE_BYTES) emit_line();
    end
    if (w.end_of_input) begin
      if (held_n > 0) emit_line();
      push_char(uule_pkg::BQ_CHAR);
      push_char(uule_pkg::NL_CHAR);
    end
    if (run_chars_q.size() > 0) begin
      tail = run_chars_q.pop_back();
      tail.run_last = 1'b1;
      run_chars_q.push_back(tail);
    end
    foreach (run_chars_q[k]) owed_chars_q.push_back(run_chars_q[k]);
  endfunction

  always @(posedge clk) begin
    uule_pkg::out_word_t want;
    int                  errs;
    errs = 0;
    if (rst) begin
      held_n = 0;
      owed_chars_q.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) predict_word(in_word);
      if (out_valid && out_ready) begin
        if (owed_chars_q.size() == 0) begin
          $error("out_char: expected none, got %0d", out_word.out_char);
          errs++;
        end else begin
          want = owed_chars_q.pop_front();
          if (out_word.out_char !== want.out_char) begin
            $error("out_char: expected %0d, got %0d", want.out_char, out_word.out_char);
            errs++;
          end
          if (out_word.run_last !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_word.run_last);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
    chars_owed <= owed_chars_q.size();
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives byte and end-of-input words into the uuencode line encoder under
// several idling patterns and gives the verdict from the checker's counts.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LINE_BYTES   = 45;
  // Extra wait after the last owed character, to catch stray words
  localparam int DRAIN_CYCLES = 200;
  localparam int OWED_LIMIT   = 200000;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  uule_pkg::in_word_t  in_word;
  logic                out_valid;
  logic                out_ready;
  uule_pkg::out_word_t out_word;
  int                  fail_count;
  int                  chars_owed;

  // Idle odds in percent, changed per phase
  int        idle_pct;
  int        stall_pct;

  uuencode_line_encoder #(
    .LINE_BYTES(LINE_BYTES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  uule_checker #(
    .LINE_BYTES(LINE_BYTES)
  ) line_check (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .fail_count(fail_count),
    .chars_owed(chars_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver side: stall at the odds of the current phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one word and hold it until accepted. Valid is only dropped when a
  // gap is taken, so back-to-back words never lower and raise valid in the
  // same step. The caller drops valid after the last word.
  task automatic send_word(input logic has, input logic [7:0] data, input logic eoi);
    uule_pkg::in_word_t w;
    w.has_byte     = has;
    w.data_byte    = data;
    w.end_of_input = eoi;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly well-formed lines: a run of random bytes closed by an end marker,
  // either on the last byte or as a bare marker. Some runs are long enough to
  // fill a whole line first. Ignored words are sprinkled in as noise and do
  // not count toward n_items.
  task automatic send_random_lines(input int n_items);
    int   sent;
    int   len;
    logic eoi_on_byte;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(50, 40) : $urandom_range(8);
      eoi_on_byte = $urandom_range(1);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(9) == 0) send_word(1'b0, 8'($urandom), 1'b0);
        send_word(1'b1, 8'($urandom), eoi_on_byte && (k == len - 1));
        sent++;
      end
      if (!eoi_on_byte || len == 0) begin
        send_word(1'b0, 8'($urandom), 1'b1);
        sent++;
      end
    end
  endtask

  initial begin
    int waited;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_word   = '0;
    out_ready = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words, no idling
    send_word(1'b0, 8'h00, 1'b1);              // end with nothing held
    send_word(1'b0, 8'hFF, 1'b0);              // no byte, no end: ignored
    send_word(1'b0, 8'h5A, 1'b1);              // stray data with end only
    send_word(1'b1, 8'hFF, 1'b1);              // byte and end together
    send_word(1'b1, 8'h00, 1'b0);              // two-byte short group
    send_word(1'b1, 8'hFF, 1'b0);
    send_word(1'b0, 8'h00, 1'b1);
    send_word(1'b1, 8'h00, 1'b0);              // all-zero group: backquotes
    send_word(1'b1, 8'h00, 1'b0);
    send_word(1'b1, 8'h00, 1'b1);
    send_word(1'b1, 8'hFF, 1'b0);              // full group, then two left over
    send_word(1'b1, 8'hFF, 1'b0);
    send_word(1'b1, 8'hFF, 1'b0);
    send_word(1'b1, 8'h80, 1'b0);
    send_word(1'b1, 8'h01, 1'b1);
    send_word(1'b1, 8'hAA, 1'b0);              // alternating bit patterns
    send_word(1'b1, 8'h55, 1'b0);
    send_word(1'b1, 8'h0F, 1'b0);
    send_word(1'b1, 8'hF0, 1'b1);

    // Random phases: free flow, sender gaps, receiver stalls, both
    send_random_lines(20);
    idle_pct  = 78;
    stall_pct = 0;
    send_random_lines(20);
    idle_pct  = 0;
    stall_pct = 78;
    send_random_lines(20);
    idle_pct  = 18;
    stall_pct = 18;
    send_random_lines(20);
    in_valid <= 1'b0;

    // Let the encoder drain, then watch for stray words
    stall_pct = 0;
    waited    = 0;
    @(posedge clk);
    while (chars_owed != 0 && waited < OWED_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && chars_owed == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
